[rtl/hpts_pkg.sv]
// Package with the entry types and the codes of the host and port traffic statistics block.
`timescale 1ns / 1ps
package hpts_pkg;

    typedef struct packed {
        logic [31:0] addr;
        logic [63:0] pkts_sent;
        logic [63:0] pkts_rcvd;
        logic [63:0] tx_bytes;
        logic [63:0] bytes_rcvd;
        logic [31:0] first_time;
        logic [31:0] last_time;
    } t_host;

    typedef struct packed {
        logic [15:0] number;
        logic [63:0] hits;
        logic [63:0] bytes;
        logic [31:0] last_active;
    } t_port;

    localparam int HOST_W = $bits(t_host);
    localparam int PORT_W = $bits(t_port);

    localparam logic [1:0] OP_PACKET    = 2'd0;
    localparam logic [1:0] OP_RD_GLOBAL = 2'd1;
    localparam logic [1:0] OP_RD_HOST   = 2'd2;
    localparam logic [1:0] OP_RD_PORT   = 2'd3;

    localparam logic [1:0] CLS_TCP   = 2'd0;
    localparam logic [1:0] CLS_UDP   = 2'd1;
    localparam logic [1:0] CLS_ICMP  = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;

    localparam logic [8:0] NO_SLOT = 9'd256;

    localparam int N_GLOBAL = 6;
    localparam int G_PKTS  = 0;
    localparam int G_BYTES = 1;
    localparam int G_TCP   = 2;
    localparam int G_UDP   = 3;
    localparam int G_ICMP  = 4;
    localparam int G_OTHER = 5;

    localparam logic [2:0] HW_ADDR  = 3'd0;
    localparam logic [2:0] HW_PSENT = 3'd1;
    localparam logic [2:0] HW_PRCVD = 3'd2;
    localparam logic [2:0] HW_BSENT = 3'd3;
    localparam logic [2:0] HW_BRCVD = 3'd4;
    localparam logic [2:0] HW_FIRST = 3'd5;
    localparam logic [2:0] HW_LAST  = 3'd6;

    localparam logic [2:0] PW_NUM   = 3'd0;
    localparam logic [2:0] PW_HITS  = 3'd1;
    localparam logic [2:0] PW_BYTES = 3'd2;
    localparam logic [2:0] PW_LAST  = 3'd3;

endpackage

[rtl/hpts_cell.sv]
// One cell of a rotating table ring: holds one entry and takes its neighbour's entry on a shift.
`timescale 1ns / 1ps
module hpts_cell #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_shift,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule

[rtl/host_port_traffic_stats.sv]
// Top level of the host and port traffic statistics block.
`timescale 1ns / 1ps
// Host and port traffic statistics. Each table is a ring of cells that rotates one entry per
// cycle past a single compare-and-update point, so one search takes exactly one full turn of
// the ring. An IPv4 TCP or UDP packet runs source and destination searches of the host ring,
// then of the port ring; other IPv4 packets run the host searches only. A host or port read
// takes one turn of its ring; non-IPv4 packets and global counter reads need no turn. busy is
// high while a turn runs. Each result appears for exactly one cycle with o_valid high; the
// receiver cannot stall it, so it must take every result as it comes.
module host_port_traffic_stats #(
    parameter int HOST_ENTRIES = 256,
    parameter int PORT_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_destination_address,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_destination_port,
    input  logic [15:0] i_frame_length,
    input  logic [31:0] i_now_time,
    input  logic [7:0]  i_read_index,
    input  logic [2:0]  i_word_select,
    output logic        o_valid,
    output logic [1:0]  o_packet_class,
    output logic [8:0]  o_source_host_slot,
    output logic [8:0]  o_destination_host_slot,
    output logic [8:0]  o_source_port_slot,
    output logic [8:0]  o_destination_port_slot,
    output logic [1:0]  o_table_full_flags,
    output logic [63:0] o_read_data,
    output logic        o_read_valid
);
    import hpts_pkg::*;

    localparam int HPW = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
    localparam int PPW = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int HUW = $clog2(HOST_ENTRIES + 1);
    localparam int PUW = $clog2(PORT_ENTRIES + 1);
    localparam logic [HPW-1:0] HLAST = HPW'(HOST_ENTRIES - 1);
    localparam logic [PPW-1:0] PLAST = PPW'(PORT_ENTRIES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HSRC = 3'd1;
    localparam logic [2:0] S_HDST = 3'd2;
    localparam logic [2:0] S_PSRC = 3'd3;
    localparam logic [2:0] S_PDST = 3'd4;
    localparam logic [2:0] S_RDH  = 3'd5;
    localparam logic [2:0] S_RDP  = 3'd6;

    logic [2:0]     r_state;
    logic [HPW-1:0] r_hpos;
    logic [PPW-1:0] r_ppos;
    logic [HUW-1:0] r_hused;
    logic [PUW-1:0] r_pused;
    logic           r_found;
    logic [63:0]    r_glob [N_GLOBAL];

    logic [7:0]  r_proto;
    logic [31:0] r_saddr, r_daddr, r_now;
    logic [15:0] r_sport, r_dport, r_len;
    logic [7:0]  r_idx;
    logic [2:0]  r_sel;

    logic        r_valid;
    logic [1:0]  r_cls, r_flags;
    logic [8:0]  r_hs, r_hd, r_ps, r_pd;
    logic [63:0] r_rdata;
    logic        r_rvalid;

    // Host ring.
    logic [HOST_W-1:0] h_q [HOST_ENTRIES];
    logic [HOST_W-1:0] h_in;
    logic              h_shift;
    t_host             h_head, h_new;
    logic              h_hit, h_app, h_snd;
    logic [31:0]       h_key;
    logic [63:0]       h_word;

    // Port ring.
    logic [PORT_W-1:0] p_q [PORT_ENTRIES];
    logic [PORT_W-1:0] p_in;
    logic              p_shift;
    t_port             p_head, p_new;
    logic              p_hit, p_app;
    logic [15:0]       p_key;
    logic [63:0]       p_word;

    assign h_shift = (r_state == S_HSRC) || (r_state == S_HDST) || (r_state == S_RDH);
    assign p_shift = (r_state == S_PSRC) || (r_state == S_PDST) || (r_state == S_RDP);

    genvar k;
    generate
        for (k = 0; k < HOST_ENTRIES; k++) begin : g_hcell
            if (k == HOST_ENTRIES - 1) begin : g_last
                hpts_cell #(.W(HOST_W)) u_cell (
                    .i_clk(i_clk), .i_shift(h_shift), .i_d(h_in), .o_q(h_q[k])
                );
            end else begin : g_mid
                hpts_cell #(.W(HOST_W)) u_cell (
                    .i_clk(i_clk), .i_shift(h_shift), .i_d(h_q[k+1]), .o_q(h_q[k])
                );
            end
        end
        for (k = 0; k < PORT_ENTRIES; k++) begin : g_pcell
            if (k == PORT_ENTRIES - 1) begin : g_last
                hpts_cell #(.W(PORT_W)) u_cell (
                    .i_clk(i_clk), .i_shift(p_shift), .i_d(p_in), .o_q(p_q[k])
                );
            end else begin : g_mid
                hpts_cell #(.W(PORT_W)) u_cell (
                    .i_clk(i_clk), .i_shift(p_shift), .i_d(p_q[k+1]), .o_q(p_q[k])
                );
            end
        end
    endgenerate

    // The entry at cell 0 during pass position p is table entry p.
    always_comb begin
        h_head = t_host'(h_q[0]);
        h_snd  = (r_state == S_HSRC);
        h_key  = h_snd ? r_saddr : r_daddr;
        h_hit  = 1'b0;
        h_app  = 1'b0;
        if ((r_state == S_HSRC) || (r_state == S_HDST)) begin
            h_hit = !r_found && (32'(r_hpos) < 32'(r_hused)) && (h_head.addr == h_key);
            h_app = !r_found && (32'(r_hpos) == 32'(r_hused));
        end
        h_new = h_head;
        if (h_hit) begin
            if (h_snd) begin
                h_new.pkts_sent = h_head.pkts_sent + 64'd1;
                h_new.tx_bytes  = h_head.tx_bytes + 64'(r_len);
            end else begin
                h_new.pkts_rcvd  = h_head.pkts_rcvd + 64'd1;
                h_new.bytes_rcvd = h_head.bytes_rcvd + 64'(r_len);
            end
            h_new.last_time = r_now;
        end else if (h_app) begin
            h_new.addr       = h_key;
            h_new.pkts_sent  = h_snd ? 64'd1 : 64'd0;
            h_new.tx_bytes   = h_snd ? 64'(r_len) : 64'd0;
            h_new.pkts_rcvd  = h_snd ? 64'd0 : 64'd1;
            h_new.bytes_rcvd = h_snd ? 64'd0 : 64'(r_len);
            h_new.first_time = r_now;
            h_new.last_time  = r_now;
        end
        h_in = HOST_W'(h_new);

        unique case (r_sel)
            HW_ADDR:  h_word = 64'(h_head.addr);
            HW_PSENT: h_word = h_head.pkts_sent;
            HW_PRCVD: h_word = h_head.pkts_rcvd;
            HW_BSENT: h_word = h_head.tx_bytes;
            HW_BRCVD: h_word = h_head.bytes_rcvd;
            HW_FIRST: h_word = 64'(h_head.first_time);
            HW_LAST:  h_word = 64'(h_head.last_time);
            default:  h_word = 64'd0;
        endcase
    end

    always_comb begin
        p_head = t_port'(p_q[0]);
        p_key  = (r_state == S_PSRC) ? r_sport : r_dport;
        p_hit  = 1'b0;
        p_app  = 1'b0;
        if ((r_state == S_PSRC) || (r_state == S_PDST)) begin
            p_hit = !r_found && (32'(r_ppos) < 32'(r_pused)) && (p_head.number == p_key);
            p_app = !r_found && (32'(r_ppos) == 32'(r_pused));
        end
        p_new = p_head;
        if (p_hit) begin
            p_new.hits        = p_head.hits + 64'd1;
            p_new.bytes       = p_head.bytes + 64'(r_len);
            p_new.last_active = r_now;
        end else if (p_app) begin
            p_new.number      = p_key;
            p_new.hits        = 64'd1;
            p_new.bytes       = 64'(r_len);
            p_new.last_active = r_now;
        end
        p_in = PORT_W'(p_new);

        unique case (r_sel)
            PW_NUM:   p_word = 64'(p_head.number);
            PW_HITS:  p_word = p_head.hits;
            PW_BYTES: p_word = p_head.bytes;
            PW_LAST:  p_word = 64'(p_head.last_active);
            default:  p_word = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hused <= '0;
            r_pused <= '0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_hpos  <= '0;
            r_ppos  <= '0;
            for (int g = 0; g < N_GLOBAL; g++) begin
                r_glob[g] <= 64'd0;
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_proto <= i_ip_protocol;
                        r_saddr <= i_source_address;
                        r_daddr <= i_destination_address;
                        r_sport <= i_source_port;
                        r_dport <= i_destination_port;
                        r_len   <= i_frame_length;
                        r_now   <= i_now_time;
                        r_idx   <= i_read_index;
                        r_sel   <= i_word_select;
                        r_cls   <= CLS_TCP;
                        r_flags <= 2'd0;
                        r_hs    <= NO_SLOT;
                        r_hd    <= NO_SLOT;
                        r_ps    <= NO_SLOT;
                        r_pd    <= NO_SLOT;
                        r_rdata <= 64'd0;
                        r_rvalid <= 1'b0;
                        r_found <= 1'b0;
                        r_hpos  <= '0;
                        r_ppos  <= '0;
                        unique case (i_opcode)
                            OP_PACKET: begin
                                r_glob[G_PKTS]  <= r_glob[G_PKTS] + 64'd1;
                                r_glob[G_BYTES] <= r_glob[G_BYTES] + 64'(i_frame_length);
                                if (i_ether_type != ETH_IPV4) begin
                                    r_glob[G_OTHER] <= r_glob[G_OTHER] + 64'd1;
                                    r_cls   <= CLS_OTHER;
                                    r_valid <= 1'b1;
                                end else begin
                                    if (i_ip_protocol == PROTO_TCP) begin
                                        r_glob[G_TCP] <= r_glob[G_TCP] + 64'd1;
                                        r_cls <= CLS_TCP;
                                    end else if (i_ip_protocol == PROTO_UDP) begin
                                        r_glob[G_UDP] <= r_glob[G_UDP] + 64'd1;
                                        r_cls <= CLS_UDP;
                                    end else if (i_ip_protocol == PROTO_ICMP) begin
                                        r_glob[G_ICMP] <= r_glob[G_ICMP] + 64'd1;
                                        r_cls <= CLS_ICMP;
                                    end else begin
                                        r_glob[G_OTHER] <= r_glob[G_OTHER] + 64'd1;
                                        r_cls <= CLS_OTHER;
                                    end
                                    r_state <= S_HSRC;
                                end
                            end
                            OP_RD_GLOBAL: begin
                                if (32'(i_read_index) < N_GLOBAL) begin
                                    r_rvalid <= 1'b1;
                                    r_rdata  <= r_glob[i_read_index[2:0]];
                                end
                                r_valid <= 1'b1;
                            end
                            OP_RD_HOST: begin
                                r_rvalid <= 32'(i_read_index) < 32'(r_hused);
                                r_state  <= S_RDH;
                            end
                            default: begin
                                r_rvalid <= 32'(i_read_index) < 32'(r_pused);
                                r_state  <= S_RDP;
                            end
                        endcase
                    end
                end
                S_HSRC, S_HDST: begin
                    r_hpos <= r_hpos + HPW'(1);
                    if (h_hit || h_app) begin
                        r_found <= 1'b1;
                        if (r_state == S_HSRC) begin
                            r_hs <= 9'(r_hpos);
                        end else begin
                            r_hd <= 9'(r_hpos);
                        end
                    end
                    if (h_app) begin
                        r_hused <= r_hused + HUW'(1);
                    end
                    if (r_hpos == HLAST) begin
                        r_hpos  <= '0;
                        r_found <= 1'b0;
                        if (!(r_found || h_hit || h_app)) begin
                            r_flags[0] <= 1'b1;
                        end
                        if (r_state == S_HSRC) begin
                            r_state <= S_HDST;
                        end else if ((r_proto == PROTO_TCP) || (r_proto == PROTO_UDP)) begin
                            r_state <= S_PSRC;
                        end else begin
                            r_state <= S_IDLE;
                            r_valid <= 1'b1;
                        end
                    end
                end
                S_PSRC, S_PDST: begin
                    r_ppos <= r_ppos + PPW'(1);
                    if (p_hit || p_app) begin
                        r_found <= 1'b1;
                        if (r_state == S_PSRC) begin
                            r_ps <= 9'(r_ppos);
                        end else begin
                            r_pd <= 9'(r_ppos);
                        end
                    end
                    if (p_app) begin
                        r_pused <= r_pused + PUW'(1);
                    end
                    if (r_ppos == PLAST) begin
                        r_ppos  <= '0;
                        r_found <= 1'b0;
                        if (!(r_found || p_hit || p_app)) begin
                            r_flags[1] <= 1'b1;
                        end
                        if (r_state == S_PSRC) begin
                            r_state <= S_PDST;
                        end else begin
                            r_state <= S_IDLE;
                            r_valid <= 1'b1;
                        end
                    end
                end
                S_RDH: begin
                    r_hpos <= r_hpos + HPW'(1);
                    if (r_rvalid && (32'(r_hpos) == 32'(r_idx))) begin
                        r_rdata <= h_word;
                    end
                    if (r_hpos == HLAST) begin
                        r_hpos  <= '0;
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                S_RDP: begin
                    r_ppos <= r_ppos + PPW'(1);
                    if (r_rvalid && (32'(r_ppos) == 32'(r_idx))) begin
                        r_rdata <= p_word;
                    end
                    if (r_ppos == PLAST) begin
                        r_ppos  <= '0;
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy                    = (r_state != S_IDLE);
    assign o_valid                 = r_valid;
    assign o_packet_class          = r_cls;
    assign o_source_host_slot      = r_hs;
    assign o_destination_host_slot = r_hd;
    assign o_source_port_slot      = r_ps;
    assign o_destination_port_slot = r_pd;
    assign o_table_full_flags      = r_flags;
    assign o_read_data             = r_rdata;
    assign o_read_valid            = r_rvalid;
endmodule

[tb/sv/tb_host_port_traffic_stats.sv]
// Testbench for the host and port traffic statistics block: random and directed transactions
// checked against a predictor.
`timescale 1ns / 1ps
module tb_host_port_traffic_stats;
    import hpts_pkg::*;

    localparam int  TABLE_SLOTS = 256;
    localparam int  RANDOM_ITEMS = 550;
    localparam int  SETTLE_CYCLES = 1100;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] len;
        logic [31:0] now;
        logic [7:0]  idx;
        logic [2:0]  sel;
        bit          drain;
    } t_req;

    typedef struct {
        logic [1:0]  cls;
        logic [8:0]  hs;
        logic [8:0]  hd;
        logic [8:0]  ps;
        logic [8:0]  pd;
        logic [1:0]  flags;
        logic [63:0] data;
        logic        rv;
    } t_stats_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_ether_type = '0;
    logic [7:0]  i_ip_protocol = '0;
    logic [31:0] i_source_address = '0;
    logic [31:0] i_destination_address = '0;
    logic [15:0] i_source_port = '0;
    logic [15:0] i_destination_port = '0;
    logic [15:0] i_frame_length = '0;
    logic [31:0] i_now_time = '0;
    logic [7:0]  i_read_index = '0;
    logic [2:0]  i_word_select = '0;
    logic        o_valid;
    logic [1:0]  o_packet_class;
    logic [8:0]  o_source_host_slot;
    logic [8:0]  o_destination_host_slot;
    logic [8:0]  o_source_port_slot;
    logic [8:0]  o_destination_port_slot;
    logic [1:0]  o_table_full_flags;
    logic [63:0] o_read_data;
    logic        o_read_valid;

    host_port_traffic_stats i_dut (.*);

    // Predictor state.
    t_host       host_tab [TABLE_SLOTS];
    t_port       port_tab [TABLE_SLOTS];
    int          hosts_in_use;
    int          ports_in_use;
    logic [63:0] totals [N_GLOBAL];

    t_req        pending_q [$];
    t_stats_res  expected_q [$];
    logic [31:0] addr_pool [$];
    logic [15:0] port_pool [$];

    int     n_errors;
    int     gap_left;
    longint n_cycles;
    int     n_class [4];
    int     n_reads;
    int     n_reads_valid;
    int     n_host_refused;
    int     n_port_refused;

    function automatic logic [8:0] update_host(logic [31:0] addr, logic [15:0] len,
                                               bit sender, logic [31:0] now);
        for (int i = 0; i < hosts_in_use; i++) begin
            if (host_tab[i].addr == addr) begin
                if (sender) begin
                    host_tab[i].pkts_sent += 64'd1;
                    host_tab[i].tx_bytes  += 64'(len);
                end else begin
                    host_tab[i].pkts_rcvd  += 64'd1;
                    host_tab[i].bytes_rcvd += 64'(len);
                end
                host_tab[i].last_time = now;
                return 9'(i);
            end
        end
        if (hosts_in_use >= TABLE_SLOTS) return NO_SLOT;
        host_tab[hosts_in_use].addr       = addr;
        host_tab[hosts_in_use].pkts_sent  = sender ? 64'd1 : 64'd0;
        host_tab[hosts_in_use].tx_bytes   = sender ? 64'(len) : 64'd0;
        host_tab[hosts_in_use].pkts_rcvd  = sender ? 64'd0 : 64'd1;
        host_tab[hosts_in_use].bytes_rcvd = sender ? 64'd0 : 64'(len);
        host_tab[hosts_in_use].first_time = now;
        host_tab[hosts_in_use].last_time  = now;
        hosts_in_use++;
        return 9'(hosts_in_use - 1);
    endfunction

    function automatic logic [8:0] update_port(logic [15:0] num, logic [15:0] len,
                                               logic [31:0] now);
        for (int i = 0; i < ports_in_use; i++) begin
            if (port_tab[i].number == num) begin
                port_tab[i].hits        += 64'd1;
                port_tab[i].bytes       += 64'(len);
                port_tab[i].last_active = now;
                return 9'(i);
            end
        end
        if (ports_in_use >= TABLE_SLOTS) return NO_SLOT;
        port_tab[ports_in_use].number      = num;
        port_tab[ports_in_use].hits        = 64'd1;
        port_tab[ports_in_use].bytes       = 64'(len);
        port_tab[ports_in_use].last_active = now;
        ports_in_use++;
        return 9'(ports_in_use - 1);
    endfunction

    function automatic t_stats_res predict_stats(t_req r);
        t_stats_res res;
        res = '{cls: CLS_TCP, hs: NO_SLOT, hd: NO_SLOT, ps: NO_SLOT, pd: NO_SLOT,
                flags: 2'b00, data: 64'd0, rv: 1'b0};
        case (r.op)
            OP_PACKET: begin
                totals[G_PKTS]  += 64'd1;
                totals[G_BYTES] += 64'(r.len);
                if (r.etype != ETH_IPV4) begin
                    totals[G_OTHER] += 64'd1;
                    res.cls = CLS_OTHER;
                end else begin
                    res.hs = update_host(r.saddr, r.len, 1'b1, r.now);
                    res.hd = update_host(r.daddr, r.len, 1'b0, r.now);
                    if (res.hs == NO_SLOT || res.hd == NO_SLOT) res.flags[0] = 1'b1;
                    if (r.proto == PROTO_TCP || r.proto == PROTO_UDP) begin
                        totals[r.proto == PROTO_TCP ? G_TCP : G_UDP] += 64'd1;
                        res.cls = (r.proto == PROTO_TCP) ? CLS_TCP : CLS_UDP;
                        res.ps = update_port(r.sport, r.len, r.now);
                        res.pd = update_port(r.dport, r.len, r.now);
                        if (res.ps == NO_SLOT || res.pd == NO_SLOT) res.flags[1] = 1'b1;
                    end else if (r.proto == PROTO_ICMP) begin
                        totals[G_ICMP] += 64'd1;
                        res.cls = CLS_ICMP;
                    end else begin
                        totals[G_OTHER] += 64'd1;
                        res.cls = CLS_OTHER;
                    end
                end
                n_class[res.cls]++;
                n_host_refused += res.flags[0];
                n_port_refused += res.flags[1];
            end
            OP_RD_GLOBAL: begin
                if (r.idx < N_GLOBAL) begin
                    res.rv   = 1'b1;
                    res.data = totals[r.idx];
                end
            end
            OP_RD_HOST: begin
                if (r.idx < hosts_in_use) begin
                    res.rv = 1'b1;
                    case (r.sel)
                        HW_ADDR:  res.data = 64'(host_tab[r.idx].addr);
                        HW_PSENT: res.data = host_tab[r.idx].pkts_sent;
                        HW_PRCVD: res.data = host_tab[r.idx].pkts_rcvd;
                        HW_BSENT: res.data = host_tab[r.idx].tx_bytes;
                        HW_BRCVD: res.data = host_tab[r.idx].bytes_rcvd;
                        HW_FIRST: res.data = 64'(host_tab[r.idx].first_time);
                        HW_LAST:  res.data = 64'(host_tab[r.idx].last_time);
                        default:  res.data = 64'd0;
                    endcase
                end
            end
            default: begin
                if (r.idx < ports_in_use) begin
                    res.rv = 1'b1;
                    case (r.sel)
                        PW_NUM:   res.data = 64'(port_tab[r.idx].number);
                        PW_HITS:  res.data = port_tab[r.idx].hits;
                        PW_BYTES: res.data = port_tab[r.idx].bytes;
                        PW_LAST:  res.data = 64'(port_tab[r.idx].last_active);
                        default:  res.data = 64'd0;
                    endcase
                end
            end
        endcase
        if (r.op != OP_PACKET) begin
            n_reads++;
            n_reads_valid += res.rv;
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        n_errors++;
    endtask

    // Unused fields of every transaction carry random junk.
    function automatic t_req junk_req();
        t_req r;
        r.op = OP_PACKET;
        r.etype = 16'($urandom);
        r.proto = 8'($urandom);
        r.saddr = $urandom;
        r.daddr = $urandom;
        r.sport = 16'($urandom);
        r.dport = 16'($urandom);
        r.len = 16'($urandom);
        r.now = $urandom;
        r.idx = 8'($urandom);
        r.sel = 3'($urandom);
        r.drain = 1'b0;
        return r;
    endfunction

    function automatic t_req read_req(logic [1:0] op, logic [7:0] idx, logic [2:0] sel);
        t_req r;
        r = junk_req();
        r.op = op;
        r.idx = idx;
        r.sel = sel;
        return r;
    endfunction

    function automatic t_req packet_req(logic [15:0] etype, logic [7:0] proto,
                                        logic [31:0] sa, logic [31:0] da,
                                        logic [15:0] sp, logic [15:0] dp,
                                        logic [15:0] len, logic [31:0] now);
        t_req r;
        r = junk_req();
        r.etype = etype;
        r.proto = proto;
        r.saddr = sa;
        r.daddr = da;
        r.sport = sp;
        r.dport = dp;
        r.len = len;
        r.now = now;
        return r;
    endfunction

    // Mostly fresh addresses, so that the host table fills during the run.
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        if (addr_pool.size() > 0 && $urandom_range(0, 99) < 30) begin
            a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
        end else begin
            a = $urandom;
            addr_pool.push_back(a);
        end
        return a;
    endfunction

    function automatic logic [15:0] pick_port();
        logic [15:0] p;
        if (port_pool.size() > 0 && $urandom_range(0, 99) < 25) begin
            p = port_pool[$urandom_range(0, port_pool.size() - 1)];
        end else begin
            p = 16'($urandom);
            port_pool.push_back(p);
        end
        return p;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 90) return $urandom_range(1, 5);
        return $urandom_range(20, 200);
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   k;
        r = junk_req();
        k = $urandom_range(0, 99);
        if (k < 65) begin
            k = $urandom_range(0, 99);
            if (k < 10) begin
                if (r.etype == ETH_IPV4) r.etype = ~ETH_IPV4;
                return r;
            end
            r.etype = ETH_IPV4;
            k = $urandom_range(0, 99);
            if (k < 35) r.proto = PROTO_TCP;
            else if (k < 70) r.proto = PROTO_UDP;
            else if (k < 85) r.proto = PROTO_ICMP;
            r.saddr = pick_addr();
            r.daddr = ($urandom_range(0, 99) < 5) ? r.saddr : pick_addr();
            r.sport = pick_port();
            r.dport = ($urandom_range(0, 99) < 5) ? r.sport : pick_port();
        end else if (k < 75) begin
            r.op = OP_RD_GLOBAL;
            r.idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        end else begin
            r.op = (k < 88) ? OP_RD_HOST : OP_RD_PORT;
        end
        return r;
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Driver: takes the next pending transaction once the block is free and any gap has run.
    always @(posedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) expected_q.push_back(predict_stats(pending_q.pop_front()));
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             !(pending_q[0].drain && expected_q.size() > 0)) begin
                    nxt = pending_q[0];
                    i_opcode <= nxt.op;
                    i_ether_type <= nxt.etype;
                    i_ip_protocol <= nxt.proto;
                    i_source_address <= nxt.saddr;
                    i_destination_address <= nxt.daddr;
                    i_source_port <= nxt.sport;
                    i_destination_port <= nxt.dport;
                    i_frame_length <= nxt.len;
                    i_now_time <= nxt.now;
                    i_read_index <= nxt.idx;
                    i_word_select <= nxt.sel;
                    start <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_stats_res want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with no transaction outstanding", 64'd1, 64'd0);
            end else begin
                want = expected_q.pop_front();
                if (o_packet_class !== want.cls)
                    report_mismatch("packet_class", 64'(o_packet_class), 64'(want.cls));
                if (o_source_host_slot !== want.hs)
                    report_mismatch("source_host_slot", 64'(o_source_host_slot), 64'(want.hs));
                if (o_destination_host_slot !== want.hd)
                    report_mismatch("destination_host_slot", 64'(o_destination_host_slot),
                                    64'(want.hd));
                if (o_source_port_slot !== want.ps)
                    report_mismatch("source_port_slot", 64'(o_source_port_slot), 64'(want.ps));
                if (o_destination_port_slot !== want.pd)
                    report_mismatch("destination_port_slot", 64'(o_destination_port_slot),
                                    64'(want.pd));
                if (o_table_full_flags !== want.flags)
                    report_mismatch("table_full_flags", 64'(o_table_full_flags),
                                    64'(want.flags));
                if (o_read_data !== want.data)
                    report_mismatch("read_data", o_read_data, want.data);
                if (o_read_valid !== want.rv)
                    report_mismatch("read_valid", 64'(o_read_valid), 64'(want.rv));
            end
        end
    end

    initial begin
        t_req r;
        hosts_in_use = 0;
        ports_in_use = 0;
        foreach (totals[i]) totals[i] = 64'd0;
        foreach (n_class[i]) n_class[i] = 0;
        n_errors = 0;
        n_cycles = 0;
        n_reads = 0;
        n_reads_valid = 0;
        n_host_refused = 0;
        n_port_refused = 0;

        // Directed part: empty tables, field extremes, every class and every read kind.
        pending_q.push_back(read_req(OP_RD_GLOBAL, 8'd0, 3'd0));
        pending_q.push_back(read_req(OP_RD_HOST, 8'd0, HW_ADDR));
        pending_q.push_back(read_req(OP_RD_PORT, 8'd0, PW_NUM));
        pending_q.push_back(packet_req(16'hFFFF, PROTO_TCP, '1, '1, '1, '1, 16'hFFFF, '1));
        pending_q.push_back(packet_req(ETH_IPV4, PROTO_TCP, 32'h0, 32'hFFFF_FFFF,
                                       16'h0, 16'hFFFF, 16'h0, 32'h0));
        // Same source and destination address and port: one entry is updated twice.
        pending_q.push_back(packet_req(ETH_IPV4, PROTO_UDP, 32'h0A00_0001, 32'h0A00_0001,
                                       16'd53, 16'd53, 16'hFFFF, 32'hFFFF_FFFF));
        pending_q.push_back(packet_req(ETH_IPV4, PROTO_ICMP, 32'h0, 32'h0A00_0001,
                                       16'd1, 16'd2, 16'd64, 32'd100));
        pending_q.push_back(packet_req(ETH_IPV4, 8'hFF, 32'hFFFF_FFFF, 32'h0,
                                       16'd3, 16'd4, 16'd1500, 32'd101));
        pending_q.push_back(packet_req(ETH_IPV4, PROTO_TCP, 32'hFFFF_FFFF, 32'h0,
                                       16'hFFFF, 16'h0, 16'd40, 32'd102));
        for (int i = 0; i <= N_GLOBAL; i++)
            pending_q.push_back(read_req(OP_RD_GLOBAL, 8'(i), 3'($urandom)));
        pending_q.push_back(read_req(OP_RD_GLOBAL, 8'd255, 3'd7));
        pending_q.push_back(read_req(OP_RD_HOST, 8'd1, HW_FIRST));
        pending_q.push_back(read_req(OP_RD_HOST, 8'd2, HW_LAST));
        pending_q.push_back(read_req(OP_RD_HOST, 8'd0, 3'd7));
        pending_q.push_back(read_req(OP_RD_HOST, 8'd255, HW_BSENT));
        pending_q.push_back(read_req(OP_RD_PORT, 8'd1, PW_BYTES));
        pending_q.push_back(read_req(OP_RD_PORT, 8'd0, PW_LAST));
        pending_q.push_back(read_req(OP_RD_PORT, 8'd2, 3'd4));
        pending_q.push_back(read_req(OP_RD_PORT, 8'd255, PW_HITS));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = random_req();
            // Hold off once, mid-run, until everything outstanding has come back.
            if (i == RANDOM_ITEMS / 2) r.drain = 1'b1;
            pending_q.push_back(r);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_q.size() > 0 || start || expected_q.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d TCP, %0d UDP, %0d ICMP, %0d other packets, %0d reads (%0d valid).",
                 n_class[CLS_TCP], n_class[CLS_UDP], n_class[CLS_ICMP], n_class[CLS_OTHER],
                 n_reads, n_reads_valid);
        $display("Tables ended with %0d hosts and %0d ports; %0d host and %0d port refusals.",
                 hosts_in_use, ports_in_use, n_host_refused, n_port_refused);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
